// ===== sv/ddl_pkg.sv =====
// ----------------------------------------------------------------------------
// ddl_pkg
// Shared types, sizes and helpers for the deduplicating deque list.
// ----------------------------------------------------------------------------
`default_nettype none

package ddl_pkg;

    // Sizing
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 16;
    localparam int VALUE_W    = 16;
    localparam int POS_W      = 8;
    localparam int LEN_W      = 5;
    localparam int STORE_W    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes
    typedef enum logic [3:0] {
        FN_PUSH_FRONT = 4'd0,
        FN_PUSH_BACK  = 4'd1,
        FN_POP_FRONT  = 4'd2,
        FN_POP_BACK   = 4'd3,
        FN_REMOVE     = 4'd4,
        FN_HEAD       = 4'd5,
        FN_POSITION   = 4'd6,
        FN_CONTAINS   = 4'd7,
        FN_CLEAR      = 4'd8
    } func_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } state_t;

    // Store access for one cycle
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [STORE_W-1:0] wdata;
        logic [IDX_W-1:0]   raddr;
    } mem_req_t;

    // One result item
    typedef struct packed {
        logic [VALUE_W-1:0] read_data;
        logic               present;
        logic               dropped;
        logic [LEN_W-1:0]   length;
    } result_t;

    // Logical index to physical slot of the circular store
    function automatic logic [IDX_W-1:0] ddl_phys(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] k);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(k);
        if (sum >= (CNT_W+1)'(CAPACITY)) begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return IDX_W'(sum);
    endfunction

endpackage

`default_nettype wire

// ===== sv/ddl_store.sv =====
// ----------------------------------------------------------------------------
// ddl_store
// Entry store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddl_store (
    input  wire logic                    aclk,
    input  wire ddl_pkg::mem_req_t       req,
    output logic [ddl_pkg::STORE_W-1:0]  rdata
);
    import ddl_pkg::*;

    logic [STORE_W-1:0] mem [CAPACITY];

    // write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

// ===== sv/ddl_out.sv =====
// ----------------------------------------------------------------------------
// ddl_out
// Output register for result items; frees when the consumer takes the item.
// ----------------------------------------------------------------------------
`default_nettype none

module ddl_out (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       load,
    input  wire ddl_pkg::result_t           res,
    output logic                            free,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [ddl_pkg::VALUE_W-1:0]     m_read_data,
    output logic                            m_present,
    output logic                            m_dropped,
    output logic [ddl_pkg::LEN_W-1:0]       m_length
);
    import ddl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_valid     = valid_reg;
    assign m_read_data = data_reg.read_data;
    assign m_present   = data_reg.present;
    assign m_dropped   = data_reg.dropped;
    assign m_length    = data_reg.length;

endmodule

`default_nettype wire

// ===== sv/ddl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ddl_ctrl
// Sequencer: circular head/count pointers, store scan, tail shift, results.
// ----------------------------------------------------------------------------
`default_nettype none

module ddl_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [3:0]                 s_func,
    input  wire logic [ddl_pkg::VALUE_W-1:0] s_value,
    input  wire logic [ddl_pkg::POS_W-1:0]  s_position,
    output ddl_pkg::mem_req_t               mem_req,
    input  wire logic [ddl_pkg::STORE_W-1:0] mem_rdata,
    input  wire logic                       out_free,
    output logic                            out_load,
    output ddl_pkg::result_t                out_res
);
    import ddl_pkg::*;

    state_t             state_reg,   state_next;
    func_t              func_reg,    func_next;
    logic [STORE_W-1:0] value_reg,   value_next;
    logic [IDX_W-1:0]   head_reg,    head_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [CNT_W-1:0]   k_reg,       k_next;
    logic               pend_reg,    pend_next;
    logic [VALUE_W-1:0] rd_reg,      rd_next;
    logic               present_reg, present_next;
    logic               dropped_reg, dropped_next;

    logic               hit;
    logic               scan_end;
    logic [CMP_W-1:0]   pos_eff;
    logic [CMP_W-1:0]   pos_lo;
    logic [CNT_W-1:0]   k_inc;
    logic [CNT_W-1:0]   count_dec;
    logic [IDX_W-1:0]   head_dec;

    assign hit       = pend_reg && (mem_rdata == value_reg);
    assign scan_end  = hit || (k_reg >= count_reg);
    assign k_inc     = k_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);
    assign head_dec  = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - IDX_W'(1);
    assign pos_eff   = (s_position == '0) ? CMP_W'(1) : CMP_W'(s_position);
    assign pos_lo    = pos_eff - CMP_W'(1);

    // state and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        value_reg   <= value_next;
        k_reg       <= k_next;
        rd_reg      <= rd_next;
        present_reg <= present_next;
        dropped_reg <= dropped_next;
    end

    // next state and outputs
    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        value_next    = value_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        pend_next     = 1'b0;
        rd_next       = rd_reg;
        present_next  = present_reg;
        dropped_next  = dropped_reg;
        s_ready       = 1'b0;
        out_load      = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = head_reg;
        mem_req.wdata = value_reg;
        mem_req.raddr = head_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next    = func_t'(s_func);
                    value_next   = STORE_W'(s_value);
                    k_next       = '0;
                    rd_next      = '0;
                    present_next = 1'b0;
                    dropped_next = 1'b0;
                    state_next   = ST_DONE;
                    case (func_t'(s_func))
                        FN_PUSH_FRONT, FN_PUSH_BACK, FN_REMOVE, FN_CONTAINS: begin
                            state_next = ST_SCAN;
                        end
                        FN_POP_FRONT: begin
                            if (count_reg != '0) begin
                                head_next    = ddl_phys(head_reg, CNT_W'(1));
                                count_next   = count_dec;
                                present_next = 1'b1;
                            end
                        end
                        FN_POP_BACK: begin
                            if (count_reg != '0) begin
                                count_next   = count_dec;
                                present_next = 1'b1;
                            end
                        end
                        FN_HEAD: begin
                            mem_req.raddr = head_reg;
                            if (count_reg != '0) begin
                                state_next = ST_READ;
                            end
                        end
                        FN_POSITION: begin
                            mem_req.raddr = ddl_phys(head_reg, CNT_W'(pos_lo));
                            if (pos_eff <= CMP_W'(count_reg)) begin
                                state_next = ST_READ;
                            end
                        end
                        FN_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // read issued in idle; data is here now
            ST_READ: begin
                rd_next      = VALUE_W'(mem_rdata);
                present_next = 1'b1;
                state_next   = ST_DONE;
            end

            // one read issued per cycle; the compare uses the registered data of the read before
            ST_SCAN: begin
                mem_req.raddr = ddl_phys(head_reg, k_reg);
                if (!scan_end) begin
                    pend_next = 1'b1;
                    k_next    = k_inc;
                end else begin
                    state_next = ST_DONE;
                    case (func_reg)
                        FN_CONTAINS: begin
                            present_next = hit;
                        end
                        FN_PUSH_FRONT, FN_PUSH_BACK: begin
                            if (hit) begin
                                present_next = 1'b1;
                            end else if (count_reg >= CNT_W'(CAPACITY)) begin
                                dropped_next = 1'b1;
                            end else begin
                                mem_req.we   = 1'b1;
                                present_next = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                if (func_reg == FN_PUSH_FRONT) begin
                                    mem_req.waddr = head_dec;
                                    head_next     = head_dec;
                                end else begin
                                    mem_req.waddr = ddl_phys(head_reg, count_reg);
                                end
                            end
                        end
                        FN_REMOVE: begin
                            if (hit) begin
                                present_next = 1'b1;
                                // matched index is one behind the issue index
                                k_next       = k_reg - CNT_W'(1);
                                if (k_reg == count_reg) begin
                                    count_next = count_dec;
                                end else begin
                                    state_next = ST_SHIFT_RD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // close the gap: entry k+1 moves to k
            ST_SHIFT_RD: begin
                mem_req.raddr = ddl_phys(head_reg, k_inc);
                state_next    = ST_SHIFT_WR;
            end

            ST_SHIFT_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ddl_phys(head_reg, k_reg);
                mem_req.wdata = mem_rdata;
                k_next        = k_inc;
                if (k_inc == count_dec) begin
                    count_next = count_dec;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SHIFT_RD;
                end
            end

            // hand result to output register
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_res.read_data = rd_reg;
    assign out_res.present   = present_reg;
    assign out_res.dropped   = dropped_reg;
    assign out_res.length    = LEN_W'(count_reg);

endmodule

`default_nettype wire

// ===== sv/dedup_deque_list_core.sv =====
// Sequence from acceptance to m_valid: pop, clear and unused codes go straight to done;
// head and position reads pass through the read state; push, remove and contains scan
// the list, and remove shifts each entry behind the removed one forward by one slot.
// One item is handled at a time; the next item is taken the cycle after the result
// loads. The single-port scan of the entry store sets the pace.
// Reset: synchronous active-low aresetn empties the list; store contents stay.
// ----------------------------------------------------------------------------
// dedup_deque_list_core
// Ordered list of distinct values kept in a circular entry store.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_deque_list_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [3:0]                  s_func,
    input  wire logic [ddl_pkg::VALUE_W-1:0] s_value,
    input  wire logic [ddl_pkg::POS_W-1:0]   s_position,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [ddl_pkg::VALUE_W-1:0]      m_read_data,
    output logic                             m_present,
    output logic                             m_dropped,
    output logic [ddl_pkg::LEN_W-1:0]        m_length
);
    import ddl_pkg::*;

    mem_req_t           mem_req;
    logic [STORE_W-1:0] mem_rdata;
    logic               out_free;
    logic               out_load;
    result_t            out_res;

    // entry store
    ddl_store u_store (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // sequencer
    ddl_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_value    (s_value),
        .s_position (s_position),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .out_free   (out_free),
        .out_load   (out_load),
        .out_res    (out_res)
    );

    // result register
    ddl_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (out_load),
        .res         (out_res),
        .free        (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_present   (m_present),
        .m_dropped   (m_dropped),
        .m_length    (m_length)
    );

endmodule

`default_nettype wire

// ===== sv/ddl_checker.sv =====
// ----------------------------------------------------------------------------
// ddl_checker
// Port-level checks on result items of the deduplicating deque list.
// ----------------------------------------------------------------------------
`default_nettype none

module ddl_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic [ddl_pkg::VALUE_W-1:0] m_read_data,
    input  wire logic                        m_present,
    input  wire logic                        m_dropped,
    input  wire logic [ddl_pkg::LEN_W-1:0]   m_length
);
    import ddl_pkg::*;

    // stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_present)
            && $stable(m_dropped) && $stable(m_length))
        else $error("result item changed while stalled");

    // a refused push never reports success
    a_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> !m_present)
        else $error("dropped and present both set");

    // a refused push only happens on a full list
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> m_length == LEN_W'(CAPACITY))
        else $error("push dropped while list not full");

    // nonzero read data only comes from an existing element
    a_rd_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_read_data != '0) |-> m_present)
        else $error("read data without element");

endmodule

bind dedup_deque_list_core ddl_checker u_ddl_checker (.*);

`default_nettype wire
